[rtl/wred_pkg.sv]
package wred_pkg;

   // fixed field widths
   localparam int ADDR_W = 32;
   localparam int SIZE_W = 8;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // default number of interval cells
   localparam int TABLE_DEPTH_DEF = 16;

   // action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EXEC = 2'd1;
   localparam logic [1:0] ACT_OPCODE = 2'd2;

   // instruction classes
   localparam logic [1:0] CLS_PUSHAD = 2'd1;
   localparam logic [1:0] CLS_POPAD = 2'd2;
   localparam logic [1:0] CLS_JMP = 2'd3;

   // what a beat in the cell chain asks of each cell
   typedef enum logic [1:0] {
      BEAT_WRITE = 2'd0,
      BEAT_EXEC = 2'd1,
      BEAT_FILL = 2'd2
   } kind_type;

   // one beat handed from cell to cell
   typedef struct packed {
      logic present;
      kind_type kind;
      logic [ADDR_W-1:0] first_addr;
      logic [ADDR_W-1:0] last_addr;
      logic found;
      logic [CNT_W-1:0] count;
   } beat_type;

endpackage

[rtl/written_region_exec_detector.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | action, address, write_size, opcode_class
// rsp     | out       | rsp_valid/rsp_ready  | exec_in_written, match_count, entry_valid,
//         |           |                      | entry_address, unpack_jump_seen, table_overflow
//
// one item at a time; a beat walks the chain of TABLE_DEPTH interval cells, one cell a cycle
// opcode items, action 3 and writes after the jump: no chain pass, straight to the done state
// execute items and writes that hit an interval: one scan pass, then the done state
// writes that add an interval: scan pass, then fill pass, then the done state
// synchronous reset clears cell valid bits and the control flags, not the response payload
// a stalled result does not block the next accept; the next result waits for the slot
module written_region_exec_detector #(
   parameter int TABLE_DEPTH = wred_pkg::TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_action,
   input  logic [wred_pkg::ADDR_W-1:0] req_address,
   input  logic [wred_pkg::SIZE_W-1:0] req_write_size,
   input  logic [1:0] req_opcode_class,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_exec_in_written,
   output logic [wred_pkg::CNT_W-1:0] rsp_match_count,
   output logic rsp_entry_valid,
   output logic [wred_pkg::ADDR_W-1:0] rsp_entry_address,
   output logic rsp_unpack_jump_seen,
   output logic rsp_table_overflow
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FILL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   wred_pkg::beat_type head_ff, head_in;
   wred_pkg::beat_type beats [0:TABLE_DEPTH];
   wred_pkg::beat_type tail;
   logic [TABLE_DEPTH:0] present_vec;

   logic seen_pushad_ff, seen_pushad_in;
   logic seen_popad_ff, seen_popad_in;
   logic seen_jump_ff, seen_jump_in;
   logic entry_valid_ff, entry_valid_in;
   logic [wred_pkg::ADDR_W-1:0] entry_address_ff, entry_address_in;
   logic overflow_ff, overflow_in;
   logic [wred_pkg::CNT_W-1:0] res_count_ff, res_count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [wred_pkg::CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [wred_pkg::ADDR_W-1:0] rsp_entry_address_ff, rsp_entry_address_in;
   logic rsp_jump_ff, rsp_jump_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   logic accept;
   logic [wred_pkg::ADDR_W:0] sum;
   logic [wred_pkg::ADDR_W-1:0] write_end;

   // chain of interval cells
   assign beats[0] = head_ff;
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      wred_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (beats[g]),
         .beat_out (beats[g+1])
      );
   end
   assign tail = beats[TABLE_DEPTH];

   for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_present
      assign present_vec[g] = beats[g].present;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   // write end, saturated at the top address
   assign sum = {1'b0, req_address} + {{(wred_pkg::ADDR_W + 1 - wred_pkg::SIZE_W){1'b0}},
                                       req_write_size};
   assign write_end = sum[wred_pkg::ADDR_W] ? '1 : sum[wred_pkg::ADDR_W-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      head_in.present = 1'b0;
      seen_pushad_in = seen_pushad_ff;
      seen_popad_in = seen_popad_ff;
      seen_jump_in = seen_jump_ff;
      entry_valid_in = entry_valid_ff;
      entry_address_in = entry_address_ff;
      overflow_in = overflow_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_entry_address_in = rsp_entry_address_ff;
      rsp_jump_in = rsp_jump_ff;
      rsp_overflow_in = rsp_overflow_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_count_in = '0;
               head_in.first_addr = req_address;
               head_in.last_addr = write_end;
               head_in.found = 1'b0;
               head_in.count = '0;
               state_in = ST_DONE;
               if (req_action == wred_pkg::ACT_WRITE && !seen_jump_ff) begin
                  head_in.present = 1'b1;
                  head_in.kind = wred_pkg::BEAT_WRITE;
                  state_in = ST_SCAN;
               end else if (req_action == wred_pkg::ACT_EXEC) begin
                  head_in.present = 1'b1;
                  head_in.kind = wred_pkg::BEAT_EXEC;
                  state_in = ST_SCAN;
               end else if (req_action == wred_pkg::ACT_OPCODE && !seen_jump_ff) begin
                  // pushad, popad, jmp sequence
                  if (req_opcode_class == wred_pkg::CLS_PUSHAD) begin
                     seen_pushad_in = 1'b1;
                  end else if (seen_pushad_ff && req_opcode_class == wred_pkg::CLS_POPAD) begin
                     seen_popad_in = 1'b1;
                  end else if (seen_popad_ff && req_opcode_class == wred_pkg::CLS_JMP) begin
                     seen_jump_in = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (tail.present) begin
               state_in = ST_DONE;
               if (tail.kind == wred_pkg::BEAT_EXEC) begin
                  res_count_in = tail.count;
                  if (tail.count != '0 && !entry_valid_ff) begin
                     entry_valid_in = 1'b1;
                     entry_address_in = tail.first_addr;
                  end
               end else if (!tail.found) begin
                  // no interval hit: second pass places a new one
                  head_in = tail;
                  head_in.kind = wred_pkg::BEAT_FILL;
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (tail.present) begin
               if (!tail.found) begin
                  overflow_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_count_ff;
               rsp_entry_valid_in = entry_valid_ff;
               rsp_entry_address_in = entry_address_ff;
               rsp_jump_in = seen_jump_ff;
               rsp_overflow_in = overflow_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_count_ff <= res_count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_entry_address_ff <= rsp_entry_address_in;
      rsp_jump_ff <= rsp_jump_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // control state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         seen_pushad_ff <= 1'b0;
         seen_popad_ff <= 1'b0;
         seen_jump_ff <= 1'b0;
         entry_valid_ff <= 1'b0;
         entry_address_ff <= '0;
         overflow_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         seen_pushad_ff <= seen_pushad_in;
         seen_popad_ff <= seen_popad_in;
         seen_jump_ff <= seen_jump_in;
         entry_valid_ff <= entry_valid_in;
         entry_address_ff <= entry_address_in;
         overflow_ff <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result ports
   assign rsp_valid = rsp_valid_ff;
   assign rsp_exec_in_written = (rsp_count_ff != '0);
   assign rsp_match_count = rsp_count_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_entry_address = rsp_entry_address_ff;
   assign rsp_unpack_jump_seen = rsp_jump_ff;
   assign rsp_table_overflow = rsp_overflow_ff;

   // at most one beat walks the chain
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      $countones(present_vec) <= 1)
      else $error("more than one beat in the cell chain");

   // chain is empty while a result is waiting to be loaded
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (present_vec == '0))
      else $error("beat in chain while result pending");

   // jump implies the whole sequence was seen
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      seen_jump_ff |-> (seen_popad_ff && seen_pushad_ff))
      else $error("jump flag without pushad and popad");

   // entry point latches once and holds
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      entry_valid_ff |=> (entry_valid_ff && $stable(entry_address_ff)))
      else $error("entry point changed after latching");

   // overflow is sticky
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");

endmodule

[rtl/wred_cell.sv]
module wred_cell (
   input  logic clock,
   input  logic reset,
   input  wred_pkg::beat_type beat_in,
   output wred_pkg::beat_type beat_out
);

   logic [wred_pkg::ADDR_W-1:0] low_ff, low_in;
   logic [wred_pkg::ADDR_W-1:0] high_ff, high_in;
   logic valid_ff, valid_in;
   wred_pkg::beat_type beat_ff, beat_in_nxt;

   logic ge_lo_s, le_hi_s, ge_lo_e, le_hi_e;
   logic hit_s, hit_e;

   // interval compares against both ends of the beat
   always_comb begin
      ge_lo_s = beat_in.first_addr >= low_ff;
      le_hi_s = beat_in.first_addr <= high_ff;
      ge_lo_e = beat_in.last_addr >= low_ff;
      le_hi_e = beat_in.last_addr <= high_ff;
      hit_s = valid_ff && ge_lo_s && le_hi_s;
      hit_e = valid_ff && ge_lo_e && le_hi_e;
   end

   // interval update and beat hand-off
   always_comb begin
      low_in = low_ff;
      high_in = high_ff;
      valid_in = valid_ff;
      beat_in_nxt = beat_in;
      if (beat_in.present) begin
         case (beat_in.kind)
            wred_pkg::BEAT_WRITE: begin
               // widen upward when start is inside, downward when the end is
               if (hit_s && !le_hi_e) begin
                  high_in = beat_in.last_addr;
               end
               if ((hit_s || hit_e) && !ge_lo_s) begin
                  low_in = beat_in.first_addr;
               end
               beat_in_nxt.found = beat_in.found | hit_s | hit_e;
            end
            wred_pkg::BEAT_EXEC: begin
               if (hit_s && beat_in.count != wred_pkg::CNT_MAX) begin
                  beat_in_nxt.count = beat_in.count + wred_pkg::CNT_W'(1);
               end
            end
            wred_pkg::BEAT_FILL: begin
               // first free cell takes the new interval
               if (!beat_in.found && !valid_ff) begin
                  low_in = beat_in.first_addr;
                  high_in = beat_in.last_addr;
                  valid_in = 1'b1;
                  beat_in_nxt.found = 1'b1;
               end
            end
            default: begin
               beat_in_nxt = beat_in;
            end
         endcase
      end
   end

   // interval bounds
   always_ff @(posedge clock) begin
      low_ff <= low_in;
      high_ff <= high_in;
   end

   // control state and the beat handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff <= beat_in_nxt;
      end
   end

   assign beat_out = beat_ff;

endmodule
